### design/assert_macros.svh
// Assertion helpers shared by the RTL; all are clocked on clk and masked by rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked at every edge out of reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### design/mct_pkg.sv
package mct_pkg;

  localparam int CODE_W = 5;
  typedef logic [CODE_W-1:0] code_t;

  // Letters a..z map to 0..25, the space to this code.
  localparam code_t CODE_SPACE = code_t'(26);

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [15:0] DOT_TICKS_RESET = 16'd1000;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_DOT  = 3'd1,
    PH_DASH = 3'd2,
    PH_EGAP = 3'd3,
    PH_CGAP = 3'd4,
    PH_WGAP = 3'd5
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic       tone;
    logic [2:0] phase;
    logic       accepted;
    logic       dropped;
    logic [6:0] fill_level;
  } out_item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Element count in bits 6:4, pattern in bits 3:0, first element in the
  // highest used bit, 1 = dash.
  function automatic logic [7:0] letter_rom(input code_t code);
    logic [7:0] e;
    case (code)
      5'd0:    e = 8'h21;
      5'd1:    e = 8'h48;
      5'd2:    e = 8'h4A;
      5'd3:    e = 8'h34;
      5'd4:    e = 8'h10;
      5'd5:    e = 8'h42;
      5'd6:    e = 8'h36;
      5'd7:    e = 8'h40;
      5'd8:    e = 8'h20;
      5'd9:    e = 8'h47;
      5'd10:   e = 8'h35;
      5'd11:   e = 8'h44;
      5'd12:   e = 8'h23;
      5'd13:   e = 8'h22;
      5'd14:   e = 8'h37;
      5'd15:   e = 8'h46;
      5'd16:   e = 8'h4D;
      5'd17:   e = 8'h32;
      5'd18:   e = 8'h30;
      5'd19:   e = 8'h11;
      5'd20:   e = 8'h31;
      5'd21:   e = 8'h41;
      5'd22:   e = 8'h33;
      5'd23:   e = 8'h49;
      5'd24:   e = 8'h4B;
      5'd25:   e = 8'h4C;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

endpackage

### design/morse_code_transmitter.sv
// Morse keyer for the letters a to z and the space.
// Input channel (in_valid/in_stall/in_item): each transfer is either an
// enqueue of one ASCII character or one timer tick. dot_ticks ticks make one
// time unit; dot 1 unit, dash 3, element gap 1, character gap 2 more, word
// gap 4. Characters wait in a FIFO of FIFO_DEPTH entries; anything but a-z
// and space, or a character that finds the FIFO full, is dropped and flagged.
// Output channel (out_valid/out_stall/out_item): exactly one result per input
// transfer, giving tone, phase, accepted, dropped and the FIFO fill level
// after that item. Results are registered; throughput is one item per cycle
// while in_stall is low, set by the single state update path.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes dot_ticks; always
// ready, to be used only while the keyer is quiet.
// Reset: keyer idle, FIFO empty, dot_ticks = 1000, no result pending.
// A stalled result holds in the output register; one more result fits in a
// skid register, and in_stall rises while that skid register is occupied.
module morse_code_transmitter import mct_pkg::*; #(
  parameter int FIFO_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

`include "assert_macros.svh"

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] ASCII_A     = 8'h61;
  localparam logic [7:0] ASCII_Z     = 8'h7A;
  localparam logic [7:0] ASCII_SPACE = 8'h20;

  localparam logic [2:0] UNITS_DOT  = 3'd1;
  localparam logic [2:0] UNITS_DASH = 3'd3;
  localparam logic [2:0] UNITS_EGAP = 3'd1;
  localparam logic [2:0] UNITS_CGAP = 3'd2;
  localparam logic [2:0] UNITS_WGAP = 3'd4;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] units;
    logic [3:0] pattern;
    logic [2:0] elements;
  } keyer_t;

  function automatic keyer_t next_element(input keyer_t k);
    keyer_t     r;
    logic [2:0] elems;
    logic       is_dash;
    elems      = k.elements - 3'd1;
    is_dash    = k.pattern[elems[1:0]];
    r          = k;
    r.elements = elems;
    r.phase    = is_dash ? PH_DASH : PH_DOT;
    r.units    = is_dash ? UNITS_DASH : UNITS_DOT;
    return r;
  endfunction

  function automatic keyer_t start_char(input keyer_t k, input code_t code);
    keyer_t     r;
    logic [7:0] e;
    r = k;
    e = letter_rom(code);
    if (code >= CODE_SPACE) begin
      r.pattern  = '0;
      r.elements = '0;
      r.phase    = PH_WGAP;
      r.units    = UNITS_WGAP;
    end else begin
      r.pattern  = e[3:0];
      r.elements = e[6:4];
      r          = next_element(r);
    end
    return r;
  endfunction

  logic [15:0] dot_ticks;
  keyer_t      ks;
  keyer_t      ks_next;
  logic [15:0] tick_count;
  logic [15:0] tick_count_next;
  logic [16:0] tick_inc;
  logic [2:0]  units_dec;

  logic       in_fire;
  logic       char_ok;
  code_t      char_code;
  logic       acc;
  logic       drop;
  fifo_ctrl_t fifo_ctrl;
  fifo_stat_t fifo_stat;
  code_t      fifo_head;
  logic [CNT_W-1:0] fifo_count;
  logic [CNT_W-1:0] fill_next;
  out_item_t  res;

  out_item_t  skid_item;
  logic       skid_valid;

  assign in_stall  = skid_valid;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    char_ok   = 1'b1;
    char_code = CODE_SPACE;
    if (in_item.char_code >= ASCII_A && in_item.char_code <= ASCII_Z) begin
      char_code = CODE_W'(in_item.char_code - ASCII_A);
    end else if (in_item.char_code != ASCII_SPACE) begin
      char_ok = 1'b0;
    end
  end

  assign tick_inc  = {1'b0, tick_count} + 17'd1;
  assign units_dec = ks.units - 3'd1;

  always_comb begin
    ks_next         = ks;
    tick_count_next = tick_count;
    fifo_ctrl       = '0;
    acc             = 1'b0;
    drop            = 1'b0;
    if (in_fire) begin
      if (in_item.req_type == REQ_CHAR) begin
        if (!char_ok) begin
          drop = 1'b1;
        end else if (ks.phase == PH_IDLE) begin
          ks_next         = start_char(ks, char_code);
          tick_count_next = '0;
          acc             = 1'b1;
        end else if (!fifo_stat.full) begin
          fifo_ctrl.push = 1'b1;
          acc            = 1'b1;
        end else begin
          drop = 1'b1;
        end
      end else if (ks.phase != PH_IDLE) begin
        if (tick_inc >= {1'b0, dot_ticks}) begin
          tick_count_next = '0;
          ks_next.units   = units_dec;
          if (units_dec == 3'd0) begin
            unique case (ks.phase) inside
              PH_DOT, PH_DASH: begin
                ks_next.phase = PH_EGAP;
                ks_next.units = UNITS_EGAP;
              end
              PH_EGAP: begin
                if (ks.elements != 3'd0) begin
                  ks_next = next_element(ks);
                end else begin
                  ks_next.phase = PH_CGAP;
                  ks_next.units = UNITS_CGAP;
                end
              end
              PH_CGAP, PH_WGAP: begin
                if (!fifo_stat.empty) begin
                  fifo_ctrl.pop = 1'b1;
                  ks_next       = start_char(ks, fifo_head);
                end else begin
                  ks_next.phase = PH_IDLE;
                  ks_next.units = '0;
                end
              end
              default: begin
                ks_next.phase = PH_IDLE;
                ks_next.units = '0;
              end
            endcase
          end
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end
    end
  end

  mct_char_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (fifo_ctrl),
    .wdata (char_code),
    .stat  (fifo_stat),
    .head  (fifo_head),
    .count (fifo_count)
  );

  always_comb begin
    fill_next = fifo_count;
    if (fifo_ctrl.push) begin
      fill_next = fifo_count + CNT_W'(1);
    end else if (fifo_ctrl.pop) begin
      fill_next = fifo_count - CNT_W'(1);
    end
  end

  always_comb begin
    res.tone       = (ks_next.phase == PH_DOT) || (ks_next.phase == PH_DASH);
    res.phase      = ks_next.phase;
    res.accepted   = acc;
    res.dropped    = drop;
    res.fill_level = 7'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_ticks  <= DOT_TICKS_RESET;
      ks         <= '{phase: PH_IDLE, units: '0, pattern: '0, elements: '0};
      tick_count <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dot_ticks <= cfg_data;
      end
      ks         <= ks_next;
      tick_count <= tick_count_next;
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_item <= skid_valid ? skid_item : res;
    end else if (in_fire) begin
      skid_item <= res;
    end
  end

  `ASSERT_IMPLIES(a_skid_behind_out, skid_valid, out_valid, "skid holds a result ahead of output")
  `ASSERT_IMPLIES(a_idle_fifo_empty, ks.phase == PH_IDLE, fifo_stat.empty, "idle keyer with queued characters")
  `ASSERT_ALWAYS(a_acc_xor_drop, !(out_valid && out_item.accepted && out_item.dropped), "result both accepted and dropped")
  `ASSERT_IMPLIES(a_idle_no_units, ks.phase == PH_IDLE, tick_count == 16'd0, "tick count running while idle")

endmodule

### design/mct_char_fifo.sv
module mct_char_fifo import mct_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fifo_ctrl_t                   ctrl,
  input  code_t                        wdata,
  output fifo_stat_t                   stat,
  output code_t                        head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  code_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (ctrl.push) begin
      wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      count_next  = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      count_next  = count - CNT_W'(1);
    end
  end

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // Keep the entry at the read pointer registered; forward a write to that entry.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[wr_ptr] <= wdata;
    end
    if (ctrl.push && (wr_ptr == rd_ptr_next)) begin
      head <= wdata;
    end else begin
      head <= mem[rd_ptr_next];
    end
  end

endmodule
